// ===== hw/rtl/tesp_pkg.sv =====
package tesp_pkg;

   localparam int MaxParams      = 16;
   localparam int MaxStringBytes = 4096;
   localparam int SlotW          = $clog2(MaxParams);
   localparam int TotalW         = $clog2(MaxParams + 1);
   localparam int StrW           = $clog2(MaxStringBytes + 1);
   localparam int MaxOut         = 16;

   localparam logic [7:0] BYTE_ESC = 8'h1b;
   localparam logic [7:0] BYTE_BEL = 8'h07;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_SUB = 8'h1a;
   localparam logic [7:0] BYTE_DEL = 8'h7f;
   localparam logic [20:0] CP_REPL = 21'h00fffd;

   typedef enum logic [3:0] {
      M_GROUND, M_ESC, M_ESC_INT, M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT, M_CSI_IGN,
      M_DCS_ENTRY, M_DCS_PARAM, M_DCS_INT, M_DCS_IGN, M_DCS_PASS, M_STR_IGN, M_OSC
   } mode_type;

   typedef enum logic [2:0] {
      ACT_PRINT, ACT_EXEC, ACT_ESC, ACT_CSI, ACT_OSC_BYTE, ACT_OSC_END, ACT_OSC_ABORT
   } action_type;

   typedef enum logic [1:0] {
      CTL_IDLE, CTL_STEP, CTL_EMIT, CTL_LIST
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;      // register the incoming byte
      logic step;      // evaluate one parser step on the held byte
      logic list_load; // start walking the parameter list
      logic list_next; // advance the parameter walk
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_out;   // this step emits a single result
      logic has_list;  // this step emits a parameter list
      logic again;     // byte must be processed a second time
      logic list_end;  // current parameter is the last one
   } stat_type;

endpackage

// ===== hw/rtl/tesp_ctrl.sv =====
module tesp_ctrl import tesp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     list_mode
);

   ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_STEP;
         end
         CTL_STEP: begin
            if (stat.has_list) state_in = CTL_LIST;
            else if (stat.has_out) state_in = CTL_EMIT;
            else if (!stat.again) state_in = CTL_IDLE;
         end
         CTL_EMIT: begin
            if (!rsp_stall) state_in = stat.again ? CTL_STEP : CTL_IDLE;
         end
         CTL_LIST: begin
            if (!rsp_stall && stat.list_end) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      list_mode = (state_ff == CTL_LIST);
      case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         CTL_STEP: begin
            cmd.step      = 1'b1;
            cmd.list_load = stat.has_list;
         end
         CTL_EMIT: rsp_valid = 1'b1;
         CTL_LIST: begin
            rsp_valid     = 1'b1;
            cmd.list_next = !rsp_stall;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/tesp_data.sv =====
module tesp_data import tesp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        list_mode,
   input  logic [7:0]  req_byte_in,
   output stat_type    stat,
   output logic [2:0]  rsp_action,
   output logic [20:0] rsp_code_point,
   output logic [7:0]  rsp_final_byte,
   output logic [7:0]  rsp_intermediate,
   output logic [7:0]  rsp_private_marker,
   output logic [3:0]  rsp_param_index,
   output logic [19:0] rsp_param_value,
   output logic        rsp_param_omitted,
   output logic        rsp_param_is_sub,
   output logic        rsp_string_overflow,
   output logic        rsp_last
);

   logic [7:0]  byte_ff;
   mode_type    mode_ff, mode_in;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  left_ff, left_in;
   logic [16:0] lower_ff, lower_in;
   logic [19:0] pval_ff [MaxParams];
   logic [1:0]  pflag_ff [MaxParams];
   logic [TotalW-1:0] total_ff, total_in;
   logic        open_ff, open_in;       // a slot is open
   logic        sink_ff, sink_in;       // open slot is the overflow sink
   logic [SlotW-1:0] slot_ff, slot_in;
   logic        nsub_ff, nsub_in;
   logic [7:0]  mark_ff, mark_in;
   logic [7:0]  inter_ff, inter_in;
   logic        iovf_ff, iovf_in;
   logic [StrW-1:0] scnt_ff, scnt_in;
   logic        sovf_ff, sovf_in;
   logic        sesc_ff, sesc_in;
   logic        again_ff;               // pending reprocess after this result

   // Single result of a step.
   logic        out_v;
   action_type  out_act;
   logic [20:0] out_cp;
   logic [7:0]  out_fb;
   logic        out_ovf;
   action_type  oact_ff;
   logic [20:0] ocp_ff;
   logic [7:0]  ofb_ff, fin_ff;
   logic        oovf_ff;
   logic        olast_ff;
   logic        again_now;
   logic        again_emit;             // the repeated step will emit a result
   logic        list_now;

   // Parameter write.
   logic             pw_en;
   logic [SlotW-1:0] pw_idx;
   logic [19:0]      pw_val;
   logic [1:0]       pw_flag;

   // List walk.
   logic [4:0]  li_ff;
   logic [4:0]  lend;
   logic        lempty_ff;

   logic [7:0] b;
   logic is_fin, is_int, is_dig;
   logic [19:0] cur, grown;
   logic [20:0] cp_done;
   logic ok;

   assign b      = byte_ff;
   assign is_fin = (b >= 8'h40) && (b <= 8'h7e);
   assign is_int = (b >= 8'h20) && (b <= 8'h2f);
   assign is_dig = (b >= 8'h30) && (b <= 8'h39);
   assign cur    = pval_ff[slot_ff];
   assign grown  = 20'(cur * 20'd10) + {16'd0, b[3:0]};
   assign cp_done = {acc_ff[14:0], b[5:0]};
   assign ok = (cp_done >= {4'd0, lower_ff}) && (cp_done <= 21'h10ffff)
      && !((cp_done >= 21'h00d800) && (cp_done <= 21'h00dfff));

   // One parser step on the held byte.
   always_comb begin
      mode_in = mode_ff; acc_in = acc_ff; left_in = left_ff; lower_in = lower_ff;
      total_in = total_ff; open_in = open_ff; sink_in = sink_ff; slot_in = slot_ff;
      nsub_in = nsub_ff; mark_in = mark_ff; inter_in = inter_ff; iovf_in = iovf_ff;
      scnt_in = scnt_ff; sovf_in = sovf_ff; sesc_in = sesc_ff;
      out_v = 1'b0; out_act = ACT_PRINT; out_cp = '0; out_fb = '0; out_ovf = 1'b0;
      again_now = 1'b0; again_emit = 1'b0; list_now = 1'b0;
      pw_en = 1'b0; pw_idx = slot_ff; pw_val = '0; pw_flag = '0;

      if (mode_ff == M_GROUND) begin
         if (b == BYTE_ESC || b < 8'h20 || b == BYTE_DEL) begin
            if (left_ff != 2'd0) begin
               // Broken sequence: print replacement and take the byte again.
               out_v = 1'b1; out_cp = CP_REPL;
               acc_in = '0; left_in = '0; lower_in = '0; again_now = 1'b1;
               again_emit = (b != BYTE_ESC) && (b != BYTE_DEL);
            end else if (b == BYTE_ESC) begin
               total_in = '0; open_in = 1'b0; sink_in = 1'b0; nsub_in = 1'b0;
               mark_in = '0; inter_in = '0; iovf_in = 1'b0; mode_in = M_ESC;
            end else if (b != BYTE_DEL) begin
               out_v = 1'b1; out_act = ACT_EXEC; out_fb = b;
            end
         end else if (left_ff != 2'd0) begin
            if (b[7:6] == 2'b10) begin
               if (left_ff == 2'd1) begin
                  out_v = 1'b1; out_cp = ok ? cp_done : CP_REPL;
                  acc_in = '0; left_in = '0; lower_in = '0;
               end else begin
                  acc_in = {acc_ff[14:0], b[5:0]}; left_in = left_ff - 2'd1;
               end
            end else begin
               out_v = 1'b1; out_cp = CP_REPL;
               acc_in = '0; left_in = '0; lower_in = '0; again_now = 1'b1;
               // A new lead byte only starts a sequence; others print.
               again_emit = !b[7] || (b[7:3] == 5'b11111);
            end
         end else if (!b[7]) begin
            out_v = 1'b1; out_cp = {13'd0, b};
         end else if (b[7:5] == 3'b110) begin
            acc_in = {16'd0, b[4:0]}; left_in = 2'd1; lower_in = 17'h00080;
         end else if (b[7:4] == 4'b1110) begin
            acc_in = {17'd0, b[3:0]}; left_in = 2'd2; lower_in = 17'h00800;
         end else if (b[7:3] == 5'b11110) begin
            acc_in = {18'd0, b[2:0]}; left_in = 2'd3; lower_in = 17'h10000;
         end else begin
            out_v = 1'b1; out_cp = CP_REPL;
         end
      end else if (mode_ff inside {M_DCS_IGN, M_DCS_PASS, M_STR_IGN, M_OSC}) begin
         if (sesc_ff) begin
            sesc_in = 1'b0; scnt_in = '0;
            if (b == 8'h5c) begin
               mode_in = M_GROUND;
               if (mode_ff == M_OSC) begin
                  out_v = 1'b1; out_act = ACT_OSC_END; out_ovf = sovf_ff;
               end
            end else begin
               total_in = '0; open_in = 1'b0; sink_in = 1'b0; nsub_in = 1'b0;
               mark_in = '0; inter_in = '0; iovf_in = 1'b0; mode_in = M_ESC;
               again_now = 1'b1;
               // In the escape state only controls and dispatches emit.
               if (b < 8'h20) begin
                  again_emit = !(b inside {BYTE_ESC, BYTE_CAN, BYTE_SUB});
               end else begin
                  again_emit = (b >= 8'h30) && (b != BYTE_DEL)
                     && !(b inside {8'h50, 8'h58, 8'h5b, 8'h5d, 8'h5e, 8'h5f});
               end
               if (mode_ff == M_OSC) begin
                  out_v = 1'b1; out_act = ACT_OSC_ABORT;
               end
            end
         end else if (b == BYTE_ESC) begin
            sesc_in = 1'b1;
         end else if (b == BYTE_BEL) begin
            mode_in = M_GROUND; scnt_in = '0;
            if (mode_ff == M_OSC) begin
               out_v = 1'b1; out_act = ACT_OSC_END; out_ovf = sovf_ff;
            end
         end else if (b == BYTE_CAN || b == BYTE_SUB) begin
            mode_in = M_GROUND; scnt_in = '0;
            if (mode_ff == M_OSC) begin
               out_v = 1'b1; out_act = ACT_OSC_ABORT;
            end
         end else if (b >= 8'h20 && mode_ff == M_OSC) begin
            if (scnt_ff >= StrW'(MaxStringBytes)) begin
               sovf_in = 1'b1;
            end else begin
               scnt_in = scnt_ff + 1'b1;
               out_v = 1'b1; out_act = ACT_OSC_BYTE; out_fb = b;
            end
         end
      end else if (b == BYTE_ESC) begin
         total_in = '0; open_in = 1'b0; sink_in = 1'b0; nsub_in = 1'b0;
         mark_in = '0; inter_in = '0; iovf_in = 1'b0; mode_in = M_ESC;
      end else if (b == BYTE_CAN || b == BYTE_SUB) begin
         mode_in = M_GROUND;
      end else begin
         case (mode_ff)
            M_ESC, M_ESC_INT: begin
               if (b < 8'h20) begin
                  out_v = 1'b1; out_act = ACT_EXEC; out_fb = b;
               end else if (b == BYTE_DEL) begin
               end else if (is_int) begin
                  if (inter_ff == '0) inter_in = b; else iovf_in = 1'b1;
                  mode_in = M_ESC_INT;
               end else if (mode_ff == M_ESC && b == 8'h5b) begin
                  mode_in = M_CSI_ENTRY;
               end else if (mode_ff == M_ESC && b == 8'h5d) begin
                  scnt_in = '0; sovf_in = 1'b0; sesc_in = 1'b0; mode_in = M_OSC;
               end else if (mode_ff == M_ESC && b == 8'h50) begin
                  mode_in = M_DCS_ENTRY;
               end else if (mode_ff == M_ESC && (b == 8'h58 || b == 8'h5e || b == 8'h5f))
               begin
                  sesc_in = 1'b0; mode_in = M_STR_IGN;
               end else begin
                  mode_in = M_GROUND;
                  if (!iovf_ff) begin
                     out_v = 1'b1; out_act = ACT_ESC; out_fb = b;
                  end
               end
            end
            M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT, M_CSI_IGN,
            M_DCS_ENTRY, M_DCS_PARAM, M_DCS_INT: begin
               if (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT, M_CSI_IGN}
                   && b < 8'h20) begin
                  out_v = 1'b1; out_act = ACT_EXEC; out_fb = b;
               end else if (mode_ff == M_CSI_IGN) begin
                  if (is_fin) mode_in = M_GROUND;
               end else if (b == BYTE_DEL && mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM,
                            M_CSI_INT}) begin
               end else if (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM, M_DCS_ENTRY,
                            M_DCS_PARAM} && (is_dig || b == 8'h3b || b == 8'h3a)) begin
                  mode_in = (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM})
                     ? M_CSI_PARAM : M_DCS_PARAM;
                  if (is_dig) begin
                     if (!open_ff) begin
                        open_in = 1'b1;
                        if (total_ff < TotalW'(MaxParams)) begin
                           slot_in = SlotW'(total_ff); total_in = total_ff + 1'b1;
                           pw_en = 1'b1; pw_idx = SlotW'(total_ff);
                           pw_val = {16'd0, b[3:0]}; pw_flag = {nsub_ff, 1'b0};
                        end else begin
                           sink_in = 1'b1;
                        end
                     end else if (!sink_ff && cur <= 20'd65535) begin
                        pw_en = 1'b1; pw_val = grown; pw_flag = pflag_ff[slot_ff];
                     end
                  end else begin
                     if (!open_ff && total_ff < TotalW'(MaxParams)) begin
                        pw_en = 1'b1; pw_idx = SlotW'(total_ff);
                        pw_flag = {nsub_ff, 1'b1}; total_in = total_ff + 1'b1;
                     end
                     open_in = 1'b0; sink_in = 1'b0; nsub_in = (b == 8'h3a);
                  end
               end else if (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM}
                            && b >= 8'h3c && b <= 8'h3f) begin
                  if (mode_ff == M_CSI_ENTRY && total_ff == '0) begin
                     mark_in = b; mode_in = M_CSI_PARAM;
                  end else begin
                     mode_in = M_CSI_IGN;
                  end
               end else if (is_int) begin
                  if (inter_ff == '0) inter_in = b; else iovf_in = 1'b1;
                  mode_in = (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT})
                     ? M_CSI_INT : M_DCS_INT;
               end else if (is_fin) begin
                  if (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT}) begin
                     mode_in = M_GROUND;
                     list_now = !iovf_ff;
                  end else begin
                     scnt_in = '0; sovf_in = 1'b0; sesc_in = 1'b0; mode_in = M_DCS_PASS;
                  end
               end else begin
                  mode_in = (mode_ff inside {M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT})
                     ? M_CSI_IGN : M_DCS_IGN;
               end
            end
            default: mode_in = M_GROUND;
         endcase
      end
   end

   assign stat.has_out  = out_v;
   assign stat.has_list = list_now;
   assign stat.again    = cmd.step ? again_now : again_ff;
   assign lend = (total_ff > TotalW'(MaxOut)) ? 5'(MaxOut) : 5'(total_ff);
   assign stat.list_end = lempty_ff || (li_ff + 5'd1 >= lend);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_GROUND; acc_ff <= '0; left_ff <= '0; lower_ff <= '0;
         total_ff <= '0; open_ff <= 1'b0; sink_ff <= 1'b0; slot_ff <= '0;
         nsub_ff <= 1'b0; mark_ff <= '0; inter_ff <= '0; iovf_ff <= 1'b0;
         scnt_ff <= '0; sovf_ff <= 1'b0; sesc_ff <= 1'b0; again_ff <= 1'b0;
         li_ff <= '0; lempty_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            mode_ff <= mode_in; acc_ff <= acc_in; left_ff <= left_in;
            lower_ff <= lower_in; total_ff <= total_in; open_ff <= open_in;
            sink_ff <= sink_in; slot_ff <= slot_in; nsub_ff <= nsub_in;
            mark_ff <= mark_in; inter_ff <= inter_in; iovf_ff <= iovf_in;
            scnt_ff <= scnt_in; sovf_ff <= sovf_in; sesc_ff <= sesc_in;
            again_ff <= again_now;
         end
         if (cmd.list_load) begin
            li_ff <= '0; lempty_ff <= (total_ff == '0);
         end else if (cmd.list_next) begin
            li_ff <= li_ff + 5'd1;
         end
      end
   end

   // Payload registers: held byte, single result, parameter store.
   always_ff @(posedge clock) begin
      if (cmd.take) byte_ff <= req_byte_in;
      if (cmd.step) begin
         oact_ff <= out_act; ocp_ff <= out_cp; ofb_ff <= out_fb; oovf_ff <= out_ovf;
         olast_ff <= !(again_now && again_emit);
         fin_ff <= b;
      end
      if (cmd.step && pw_en) begin
         pval_ff[pw_idx]  <= pw_val;
         pflag_ff[pw_idx] <= pw_flag;
      end
   end

   logic [SlotW-1:0] lidx;
   logic [1:0] lflag;
   assign lidx  = SlotW'(li_ff);
   assign lflag = pflag_ff[lidx];

   // Result fields.
   always_comb begin
      rsp_action = oact_ff; rsp_code_point = ocp_ff; rsp_final_byte = ofb_ff;
      rsp_intermediate = '0; rsp_private_marker = '0; rsp_param_index = '0;
      rsp_param_value = '0; rsp_param_omitted = 1'b0; rsp_param_is_sub = 1'b0;
      rsp_string_overflow = oovf_ff; rsp_last = olast_ff;
      if (oact_ff == ACT_ESC) rsp_intermediate = inter_ff;
      if (list_mode) begin
         rsp_action = ACT_CSI; rsp_code_point = '0; rsp_final_byte = fin_ff;
         rsp_intermediate = inter_ff; rsp_private_marker = mark_ff;
         rsp_string_overflow = 1'b0; rsp_last = stat.list_end;
         rsp_param_index = li_ff[3:0];
         if (lempty_ff) begin
            rsp_param_omitted = 1'b1;
         end else begin
            rsp_param_omitted = lflag[0]; rsp_param_is_sub = lflag[1];
            rsp_param_value = lflag[0] ? 20'd0 : pval_ff[lidx];
         end
      end
   end

endmodule

// ===== hw/rtl/terminal_escape_sequence_parser.sv =====
// Terminal output byte parser with UTF-8 decoding. One byte is taken per item;
// the parser step runs in the cycle after acceptance, and each result then
// occupies the output until it is taken. A byte that breaks a UTF-8 sequence
// or aborts a string by ESC is stepped a second time, and that step may emit
// one more result. A CSI dispatch emits one result per stored parameter (up
// to 16, or a single result when none is stored), one per cycle while the
// output does not stall.
module terminal_escape_sequence_parser import tesp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [20:0] rsp_code_point,
   output logic [7:0]  rsp_final_byte,
   output logic [7:0]  rsp_intermediate,
   output logic [7:0]  rsp_private_marker,
   output logic [3:0]  rsp_param_index,
   output logic [19:0] rsp_param_value,
   output logic        rsp_param_omitted,
   output logic        rsp_param_is_sub,
   output logic        rsp_string_overflow,
   output logic        rsp_last
);

   cmd_type  cmd;
   stat_type stat;
   logic     list_mode;

   // Sequencing of each item.
   tesp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd, .list_mode
   );

   // Parser state and result fields.
   tesp_data u_data (
      .clock, .reset, .cmd, .list_mode, .req_byte_in, .stat,
      .rsp_action, .rsp_code_point, .rsp_final_byte, .rsp_intermediate,
      .rsp_private_marker, .rsp_param_index, .rsp_param_value,
      .rsp_param_omitted, .rsp_param_is_sub, .rsp_string_overflow, .rsp_last
   );

endmodule

// ===== verif/terminal_escape_sequence_parser_test.sv =====
module terminal_escape_sequence_parser_test import tesp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SlotNone = -1;

   // One result of the parser, as seen on the result channel.
   typedef struct {
      action_type  action;
      logic [20:0] code_point;
      logic [7:0]  final_byte;
      logic [7:0]  intermediate;
      logic [7:0]  private_marker;
      logic [3:0]  param_index;
      logic [19:0] param_value;
      logic        param_omitted;
      logic        param_is_sub;
      logic        string_overflow;
      logic        last;
   } parse_result_type;

   // Parser predictor and the queue of results that it still expects.
   class parse_scoreboard_type;
      mode_type    mode;
      logic [20:0] utf_acc;
      int          utf_left;
      int          utf_low;
      int          pval[MaxParams];
      bit          pomit[MaxParams];
      bit          psub[MaxParams];
      int          ptotal;
      int          open_slot;
      bit          next_sub;
      logic [7:0]  marker;
      logic [7:0]  inter;
      bit          inter_ovf;
      int          str_count;
      bit          str_ovf;
      bit          str_esc;
      parse_result_type step_q[$];
      parse_result_type expected_q[$];
      int          errors;

      function new();
         mode = M_GROUND;
         utf_acc = 0; utf_left = 0; utf_low = 0;
         foreach (pval[i]) begin
            pval[i] = 0; pomit[i] = 0; psub[i] = 0;
         end
         str_count = 0; str_ovf = 0; str_esc = 0;
         clear_seq();
         errors = 0;
      endfunction

      function void emit(action_type act, int cp, int fb, int im, int pm, int idx,
                         int val, bit om, bit sub, bit ovf);
         parse_result_type r;
         if (step_q.size() >= MaxOut) return;
         r.action = act; r.code_point = cp; r.final_byte = fb; r.intermediate = im;
         r.private_marker = pm; r.param_index = idx; r.param_value = val;
         r.param_omitted = om; r.param_is_sub = sub; r.string_overflow = ovf;
         r.last = 0;
         step_q.push_back(r);
      endfunction

      function void print_cp(int cp);
         emit(ACT_PRINT, cp, 0, 0, 0, 0, 0, 0, 0, 0);
      endfunction

      function void utf_break();
         utf_acc = 0; utf_left = 0; utf_low = 0;
         print_cp(CP_REPL);
      endfunction

      // UTF-8 decoding on the print path.
      function void decode(logic [7:0] b);
         int cp;
         if (utf_left > 0) begin
            if (b[7:6] == 2'b10) begin
               utf_acc = {utf_acc[14:0], b[5:0]};
               utf_left--;
               if (utf_left == 0) begin
                  cp = utf_acc;
                  if (cp < utf_low || cp > 'h10FFFF || (cp >= 'hD800 && cp <= 'hDFFF))
                     cp = CP_REPL;
                  utf_acc = 0; utf_low = 0;
                  print_cp(cp);
               end
               return;
            end
            utf_break();
         end
         if (b < 8'h80) print_cp(b);
         else if (b[7:5] == 3'b110) begin
            utf_acc = b[4:0]; utf_left = 1; utf_low = 'h80;
         end else if (b[7:4] == 4'b1110) begin
            utf_acc = b[3:0]; utf_left = 2; utf_low = 'h800;
         end else if (b[7:3] == 5'b11110) begin
            utf_acc = b[2:0]; utf_left = 3; utf_low = 'h10000;
         end else print_cp(CP_REPL);
      endfunction

      function void clear_seq();
         ptotal = 0; open_slot = SlotNone; next_sub = 0;
         marker = 0; inter = 0; inter_ovf = 0;
      endfunction

      function void string_reset();
         str_count = 0; str_ovf = 0; str_esc = 0;
      endfunction

      // Digits grow the open slot; beyond the last slot they go to a sink.
      function void param_digit(logic [7:0] b);
         if (open_slot < 0) begin
            if (ptotal < MaxParams) begin
               pval[ptotal] = 0; pomit[ptotal] = 0; psub[ptotal] = next_sub;
               open_slot = ptotal;
               ptotal++;
            end else open_slot = MaxParams;
         end
         if (open_slot >= 0 && open_slot < MaxParams && pval[open_slot] <= 65535)
            pval[open_slot] = pval[open_slot] * 10 + (b - 8'h30);
      endfunction

      function void param_sep(bit sub);
         if (open_slot < 0 && ptotal < MaxParams) begin
            pval[ptotal] = 0; pomit[ptotal] = 1; psub[ptotal] = next_sub;
            ptotal++;
         end
         open_slot = SlotNone;
         next_sub = sub;
      endfunction

      function void collect_int(logic [7:0] b);
         if (inter == 0) inter = b;
         else inter_ovf = 1;
      endfunction

      function void esc_dispatch(logic [7:0] b);
         mode = M_GROUND;
         if (!inter_ovf) emit(ACT_ESC, 0, b, inter, 0, 0, 0, 0, 0, 0);
      endfunction

      function void csi_dispatch(logic [7:0] b);
         mode = M_GROUND;
         if (inter_ovf) return;
         if (ptotal == 0) begin
            emit(ACT_CSI, 0, b, inter, marker, 0, 0, 1, 0, 0);
            return;
         end
         for (int i = 0; i < ptotal && i < MaxParams; i++)
            emit(ACT_CSI, 0, b, inter, marker, i, pomit[i] ? 0 : pval[i], pomit[i],
                 psub[i], 0);
      endfunction

      // One parser step; a string aborted by ESC reprocesses its byte.
      function void handle(logic [7:0] b);
         bit osc;
         bit inter_b;
         bit final_b;
         osc = (mode == M_OSC);
         inter_b = (b >= 8'h20 && b <= 8'h2F);
         final_b = (b >= 8'h40 && b <= 8'h7E);
         if (mode == M_GROUND) begin
            if (b == BYTE_ESC) begin
               if (utf_left > 0) utf_break();
               clear_seq();
               mode = M_ESC;
            end else if (b < 8'h20 || b == BYTE_DEL) begin
               if (utf_left > 0) utf_break();
               if (b != BYTE_DEL) emit(ACT_EXEC, 0, b, 0, 0, 0, 0, 0, 0, 0);
            end else decode(b);
            return;
         end
         if (mode inside {M_DCS_IGN, M_DCS_PASS, M_STR_IGN, M_OSC}) begin
            if (str_esc) begin
               str_esc = 0;
               str_count = 0;
               if (b == 8'h5C) begin
                  mode = M_GROUND;
                  if (osc) emit(ACT_OSC_END, 0, 0, 0, 0, 0, 0, 0, 0, str_ovf);
                  return;
               end
               if (osc) emit(ACT_OSC_ABORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
               clear_seq();
               mode = M_ESC;
               handle(b);
               return;
            end
            if (b == BYTE_ESC) str_esc = 1;
            else if (b == BYTE_BEL) begin
               mode = M_GROUND;
               if (osc) emit(ACT_OSC_END, 0, 0, 0, 0, 0, 0, 0, 0, str_ovf);
               str_count = 0;
            end else if (b == BYTE_CAN || b == BYTE_SUB) begin
               str_count = 0;
               mode = M_GROUND;
               if (osc) emit(ACT_OSC_ABORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            end else if (b >= 8'h20 && osc) begin
               if (str_count >= MaxStringBytes) str_ovf = 1;
               else begin
                  str_count++;
                  emit(ACT_OSC_BYTE, 0, b, 0, 0, 0, 0, 0, 0, 0);
               end
            end
            return;
         end
         // ESC restarts and CAN or SUB abort any other sequence.
         if (b == BYTE_ESC) begin
            clear_seq();
            mode = M_ESC;
            return;
         end
         if (b == BYTE_CAN || b == BYTE_SUB) begin
            mode = M_GROUND;
            return;
         end
         case (mode)
            M_ESC, M_ESC_INT: begin
               if (b < 8'h20) emit(ACT_EXEC, 0, b, 0, 0, 0, 0, 0, 0, 0);
               else if (b == BYTE_DEL) ;
               else if (inter_b) begin
                  collect_int(b);
                  mode = M_ESC_INT;
               end else if (mode == M_ESC_INT) esc_dispatch(b);
               else if (b == 8'h5B) mode = M_CSI_ENTRY;
               else if (b == 8'h5D) begin
                  string_reset();
                  mode = M_OSC;
               end else if (b == 8'h50) mode = M_DCS_ENTRY;
               else if (b == 8'h58 || b == 8'h5E || b == 8'h5F) begin
                  str_esc = 0;
                  mode = M_STR_IGN;
               end else esc_dispatch(b);
            end
            M_CSI_ENTRY, M_CSI_PARAM: begin
               if (b < 8'h20) emit(ACT_EXEC, 0, b, 0, 0, 0, 0, 0, 0, 0);
               else if (b == BYTE_DEL) ;
               else if (b >= 8'h30 && b <= 8'h39) begin
                  param_digit(b);
                  mode = M_CSI_PARAM;
               end else if (b == 8'h3B || b == 8'h3A) begin
                  param_sep(b == 8'h3A);
                  mode = M_CSI_PARAM;
               end else if (b >= 8'h3C && b <= 8'h3F) begin
                  if (mode == M_CSI_ENTRY && ptotal == 0) begin
                     marker = b;
                     mode = M_CSI_PARAM;
                  end else mode = M_CSI_IGN;
               end else if (inter_b) begin
                  collect_int(b);
                  mode = M_CSI_INT;
               end else if (final_b) csi_dispatch(b);
               else mode = M_CSI_IGN;
            end
            M_CSI_INT: begin
               if (b < 8'h20) emit(ACT_EXEC, 0, b, 0, 0, 0, 0, 0, 0, 0);
               else if (b == BYTE_DEL) ;
               else if (inter_b) collect_int(b);
               else if (final_b) csi_dispatch(b);
               else mode = M_CSI_IGN;
            end
            M_CSI_IGN: begin
               if (b < 8'h20) emit(ACT_EXEC, 0, b, 0, 0, 0, 0, 0, 0, 0);
               else if (final_b) mode = M_GROUND;
            end
            M_DCS_ENTRY, M_DCS_PARAM, M_DCS_INT: begin
               if (mode != M_DCS_INT && b >= 8'h30 && b <= 8'h39) begin
                  param_digit(b);
                  mode = M_DCS_PARAM;
               end else if (mode != M_DCS_INT && (b == 8'h3B || b == 8'h3A)) begin
                  param_sep(b == 8'h3A);
                  mode = M_DCS_PARAM;
               end else if (inter_b) begin
                  collect_int(b);
                  mode = M_DCS_INT;
               end else if (final_b) begin
                  string_reset();
                  mode = M_DCS_PASS;
               end else mode = M_DCS_IGN;
            end
            default: mode = M_GROUND;
         endcase
      endfunction

      // Notes one accepted byte and queues the results it causes.
      function void note_byte(logic [7:0] b);
         step_q.delete();
         handle(b);
         if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                     exp_v, act_v);
            errors++;
         end
      endfunction

      // Checks one result against the oldest expectation.
      function void check_result(parse_result_type a);
         parse_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual action %0d", $realtime,
                     a.action);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("action", e.action, a.action);
         compare_field("code_point", e.code_point, a.code_point);
         compare_field("final_byte", e.final_byte, a.final_byte);
         compare_field("intermediate", e.intermediate, a.intermediate);
         compare_field("private_marker", e.private_marker, a.private_marker);
         compare_field("param_index", e.param_index, a.param_index);
         compare_field("param_value", e.param_value, a.param_value);
         compare_field("param_omitted", e.param_omitted, a.param_omitted);
         compare_field("param_is_sub", e.param_is_sub, a.param_is_sub);
         compare_field("string_overflow", e.string_overflow, a.string_overflow);
         compare_field("last", e.last, a.last);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_action;
   logic [20:0] rsp_code_point;
   logic [7:0]  rsp_final_byte;
   logic [7:0]  rsp_intermediate;
   logic [7:0]  rsp_private_marker;
   logic [3:0]  rsp_param_index;
   logic [19:0] rsp_param_value;
   logic        rsp_param_omitted;
   logic        rsp_param_is_sub;
   logic        rsp_string_overflow;
   logic        rsp_last;

   parse_scoreboard_type board;
   bit              calm;
   logic [7:0]      byte_q[$];

   terminal_escape_sequence_parser dut (.*);

   // Clock.
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: check accepted results and stall at random.
   initial begin
      parse_result_type r;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            r.action = action_type'(rsp_action);
            r.code_point = rsp_code_point; r.final_byte = rsp_final_byte;
            r.intermediate = rsp_intermediate; r.private_marker = rsp_private_marker;
            r.param_index = rsp_param_index; r.param_value = rsp_param_value;
            r.param_omitted = rsp_param_omitted; r.param_is_sub = rsp_param_is_sub;
            r.string_overflow = rsp_string_overflow; r.last = rsp_last;
            board.check_result(r);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 21);
      end
   end

   // Sends one byte, then idles now and then.
   task automatic send_byte(input logic [7:0] b);
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      board.note_byte(b);
      if (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic void push_params(int count);
      int digits;
      for (int i = 0; i < count; i++) begin
         digits = $urandom_range(0, 7);
         for (int d = 0; d < digits; d++) byte_q.push_back(8'h30 + $urandom_range(9));
         if (i < count - 1) byte_q.push_back($urandom_range(3) == 0 ? 8'h3A : 8'h3B);
      end
   endfunction

   function automatic void push_intermediates(int count);
      for (int i = 0; i < count; i++) byte_q.push_back($urandom_range(8'h20, 8'h2F));
   endfunction

   // Builds one random fragment of terminal output.
   function automatic void build_fragment();
      int n;
      case ($urandom_range(11))
         0: byte_q.push_back($urandom_range(8'h20, 8'h7E));
         1: begin
            n = $urandom_range(1, 3);
            byte_q.push_back(n == 1 ? $urandom_range(8'hC0, 8'hDF) :
                             n == 2 ? $urandom_range(8'hE0, 8'hEF) :
                                      $urandom_range(8'hF0, 8'hFF));
            if ($urandom_range(4) == 0) n = $urandom_range(0, n);
            for (int i = 0; i < n; i++) byte_q.push_back($urandom_range(8'h80, 8'hBF));
         end
         2: byte_q.push_back($urandom_range(8'h00, 8'h1F));
         3: begin
            byte_q.push_back(BYTE_ESC);
            push_intermediates($urandom_range(3) == 0 ? 2 : $urandom_range(1));
            byte_q.push_back($urandom_range(8'h30, 8'h7E));
         end
         4, 5, 6: begin
            byte_q.push_back(BYTE_ESC);
            byte_q.push_back(8'h5B);
            if ($urandom_range(2) == 0) byte_q.push_back($urandom_range(8'h3C, 8'h3F));
            push_params($urandom_range(9) == 0 ? $urandom_range(16, 19) :
                        $urandom_range(0, 4));
            if ($urandom_range(15) == 0) byte_q.push_back($urandom_range(8'h3C, 8'h3F));
            if ($urandom_range(15) == 0) byte_q.push_back($urandom_range(8'h00, 8'h1F));
            if ($urandom_range(15) == 0) byte_q.push_back(BYTE_DEL);
            push_intermediates($urandom_range(5) == 0 ? 2 : $urandom_range(1));
            byte_q.push_back($urandom_range(8'h40, 8'h7E));
         end
         7, 8: begin
            byte_q.push_back(BYTE_ESC);
            byte_q.push_back(8'h5D);
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
               byte_q.push_back($urandom_range(7) == 0 ? $urandom_range(8'h00, 8'h1F)
                                                       : $urandom_range(8'h20, 8'hFF));
            case ($urandom_range(3))
               0: byte_q.push_back(BYTE_BEL);
               1: begin byte_q.push_back(BYTE_ESC); byte_q.push_back(8'h5C); end
               2: begin byte_q.push_back(BYTE_ESC); byte_q.push_back($urandom_range(255)); end
               default: byte_q.push_back($urandom_range(1) ? BYTE_CAN : BYTE_SUB);
            endcase
         end
         9: begin
            byte_q.push_back(BYTE_ESC);
            byte_q.push_back($urandom_range(1) ? 8'h50 : 8'h58);
            push_params($urandom_range(0, 3));
            push_intermediates($urandom_range(2));
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) byte_q.push_back($urandom_range(255));
            byte_q.push_back(BYTE_ESC);
            byte_q.push_back(8'h5C);
         end
         default: byte_q.push_back($urandom_range(255));
      endcase
   endfunction

   // Stimulus and end of the run.
   initial begin
      int sent;
      board = new();
      calm = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_in = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: ASCII, controls, DEL, UTF-8 good and bad, escape, CSI, OSC.
      byte_q = '{8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hF4, 8'h90, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hC0, 8'h80,
                 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'h1B, 8'h28, 8'h42, 8'h1B,
                 8'h5B, 8'h3F, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
                 8'h3B, 8'h3A, 8'h35, 8'h6D, 8'h1B, 8'h5B, 8'h6D, 8'h1B, 8'h5D,
                 8'h30, 8'h1B, 8'h5C, 8'h1A};
      sent = 0;
      while (byte_q.size() > 0) begin
         send_byte(byte_q.pop_front());
         sent++;
      end

      // Random fragments with a calm stretch in the middle.
      while (sent < 430) begin
         calm = (sent >= 200 && sent < 300);
         build_fragment();
         while (byte_q.size() > 0) begin
            send_byte(byte_q.pop_front());
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (board.expected_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tesp_pkg.sv
hw/rtl/tesp_ctrl.sv
hw/rtl/tesp_data.sv
hw/rtl/terminal_escape_sequence_parser.sv
verif/terminal_escape_sequence_parser_test.sv
